// ===== rtl/npwr_pkg.sv =====
// Package for the nearest-point-within-radius search block.
// Holds the field widths, the action codes and the request and response structs.
// Every rtl file depends on this package.
`default_nettype none

package npwr_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;
    localparam int RADIUS_W   = 23;
    localparam int RADSQ_W    = 2 * RADIUS_W;
    localparam int INDEX_W    = 10;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DIST_W     = 52;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1024);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [COORD_BITS-1:0]  coord_x;
        logic [COORD_BITS-1:0]  coord_y;
        logic [COORD_BITS-1:0]  coord_z;
    } t_in_req;

    typedef struct packed {
        logic                   found;
        logic [INDEX_W-1:0]     match_index;
        logic [DIST_W-1:0]      best_dist_sq;
        logic                   status;
    } t_out_rsp;

    typedef struct packed {
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [COORD_BITS-1:0]  z;
    } t_point;

endpackage

`default_nettype wire

// ===== rtl/npwr_store.sv =====
// Reference point memory: one write port and one read port, registered read data.
// Depends on npwr_pkg for the point type.
`default_nettype none

module npwr_store #(
    parameter  int MAX_POINTS = npwr_pkg::MAX_POINTS,
    localparam int ADDR_W     = $clog2(MAX_POINTS)
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire  [ADDR_W-1:0]     i_waddr,
    input  wire npwr_pkg::t_point i_wdata,
    input  wire                   i_re,
    input  wire  [ADDR_W-1:0]     i_raddr,
    output npwr_pkg::t_point      o_rdata
);

    npwr_pkg::t_point r_mem [MAX_POINTS];
    npwr_pkg::t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/npwr_dist.sv =====
// Three-stage squared distance pipeline: absolute differences, squares, sum.
// Carries the point index and a last-point flag alongside. Depends on npwr_pkg.
`default_nettype none

module npwr_dist #(
    parameter int ADDR_W = $clog2(npwr_pkg::MAX_POINTS)
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  wire                           i_last,
    input  wire  [ADDR_W-1:0]             i_index,
    input  wire npwr_pkg::t_point         i_ref,
    input  wire npwr_pkg::t_point         i_query,
    output logic                          o_valid,
    output logic                          o_last,
    output logic [ADDR_W-1:0]             o_index,
    output logic [npwr_pkg::DIST_W-1:0]   o_dist
);

    localparam int DW = npwr_pkg::DIFF_W;
    localparam int SW = npwr_pkg::SQ_W;
    localparam int TW = npwr_pkg::DIST_W;

    logic [2:0]        r_valid;
    logic [2:0]        r_last;
    logic [ADDR_W-1:0] r_idx [3];

    logic [DW-1:0] r_ax, r_ay, r_az;
    logic [SW-1:0] r_sx, r_sy, r_sz;
    logic [TW-1:0] r_sum;

    function automatic logic [DW-1:0] abs_diff(
        input logic [npwr_pkg::COORD_BITS-1:0] a,
        input logic [npwr_pkg::COORD_BITS-1:0] b
    );
        logic signed [DW-1:0] d;
        begin
            d = $signed({a[npwr_pkg::COORD_BITS-1], a}) -
                $signed({b[npwr_pkg::COORD_BITS-1], b});
            abs_diff = d[DW-1] ? DW'(-d) : DW'(d);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= {r_last[1:0], i_last};
        r_idx[0] <= i_index;
        r_idx[1] <= r_idx[0];
        r_idx[2] <= r_idx[1];
        r_ax     <= abs_diff(i_ref.x, i_query.x);
        r_ay     <= abs_diff(i_ref.y, i_query.y);
        r_az     <= abs_diff(i_ref.z, i_query.z);
        r_sx     <= r_ax * r_ax;
        r_sy     <= r_ay * r_ay;
        r_sz     <= r_az * r_az;
        // Three squares of at most 2^48 each cannot reach the 52-bit cap.
        r_sum    <= TW'(r_sx) + TW'(r_sy) + TW'(r_sz);
    end

    assign o_valid = r_valid[2];
    assign o_last  = r_last[2];
    assign o_index = r_idx[2];
    assign o_dist  = r_sum;

endmodule

`default_nettype wire

// ===== rtl/nearest_point_within_radius_top.sv =====
// Nearest reference point within a radius: brute-force 3D nearest-neighbor search.
// Clear and load requests go through S_RESULT to a response; a query scans the N stored
// points, reading one point per cycle from the single read port, then drains the pipeline.
// A new request is taken while a finished response waits in the output register.
// Reset clears the control state, the point count and the radius (to 1.0); stored
// coordinates are not cleared, since entries at or above the count are never read.
`default_nettype none

module nearest_point_within_radius_top #(
    parameter int MAX_POINTS = npwr_pkg::MAX_POINTS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire npwr_pkg::t_in_req              i_in_req,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output npwr_pkg::t_out_rsp                  o_out_rsp,
    input  wire                                 i_cfg_we,
    input  wire  [npwr_pkg::RADIUS_W-1:0]       i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = npwr_pkg::INDEX_W;
    localparam int TW     = npwr_pkg::DIST_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic [ADDR_W-1:0]              r_addr, n_addr;
    logic                           r_hit, n_hit;
    logic [TW-1:0]                  r_best, n_best;
    logic [ADDR_W-1:0]              r_best_i, n_best_i;
    logic                           r_status, n_status;
    npwr_pkg::t_point               r_query, n_query;
    logic                           r_out_valid, n_out_valid;
    npwr_pkg::t_out_rsp             r_out, n_out;
    logic [npwr_pkg::RADIUS_W-1:0]  r_radius;
    logic [npwr_pkg::RADSQ_W-1:0]   r_radius_sq;

    logic                           r_rd_valid, r_rd_last;
    logic [ADDR_W-1:0]              r_rd_idx;

    logic                           mem_we, mem_re;
    npwr_pkg::t_point               mem_wdata, mem_rdata;
    logic                           scan_last;

    logic                           dist_valid, dist_last;
    logic [ADDR_W-1:0]              dist_index;
    logic [TW-1:0]                  dist_value;
    logic [TW-1:0]                  bound;
    logic [IDX_W+ADDR_W-1:0]        index_wide;

    assign mem_wdata = '{x: i_in_req.coord_x, y: i_in_req.coord_y, z: i_in_req.coord_z};
    assign mem_re    = (r_state == S_SCAN);
    assign scan_last = (r_addr == ADDR_W'(r_count - CNT_W'(1)));

    npwr_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    npwr_dist #(
        .ADDR_W (ADDR_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_last  (r_rd_last),
        .i_index (r_rd_idx),
        .i_ref   (mem_rdata),
        .i_query (r_query),
        .o_valid (dist_valid),
        .o_last  (dist_last),
        .o_index (dist_index),
        .o_dist  (dist_value)
    );

    // Until the first hit the bound is the squared radius; read late so that a
    // radius written just before a query is already squared.
    assign bound      = r_hit ? r_best : TW'(r_radius_sq);
    assign index_wide = {IDX_W'(0), r_best_i};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_hit       = r_hit;
        n_best      = r_best;
        n_best_i    = r_best_i;
        n_status    = r_status;
        n_query     = r_query;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (dist_valid && (dist_value < bound)) begin
            n_hit    = 1'b1;
            n_best   = dist_value;
            n_best_i = dist_index;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_hit    = 1'b0;
                    n_best_i = '0;
                    n_status = 1'b0;
                    n_state  = S_RESULT;
                    unique case (i_in_req.action)
                        npwr_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        npwr_pkg::ACT_LOAD: begin
                            if (r_count >= CNT_W'(MAX_POINTS)) begin
                                n_status = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        npwr_pkg::ACT_QUERY: begin
                            n_query = mem_wdata;
                            n_addr  = '0;
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                if (dist_valid && dist_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out.found            = r_hit;
                    n_out.match_index      = r_hit ? index_wide[IDX_W-1:0] : '0;
                    n_out.best_dist_sq     = r_hit ? r_best : '0;
                    n_out.status           = r_status;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_radius    <= npwr_pkg::RADIUS_RESET;
            r_radius_sq <= npwr_pkg::RADSQ_W'(npwr_pkg::RADIUS_RESET) *
                           npwr_pkg::RADSQ_W'(npwr_pkg::RADIUS_RESET);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= mem_re;
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            r_radius_sq <= npwr_pkg::RADSQ_W'(r_radius) * npwr_pkg::RADSQ_W'(r_radius);
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_best    <= n_best;
        r_best_i  <= n_best_i;
        r_status  <= n_status;
        r_query   <= n_query;
        r_out     <= n_out;
        r_rd_last <= scan_last;
        r_rd_idx  <= r_addr;
    end

endmodule

`default_nettype wire

// ===== bench/nearest_point_checker.sv =====
// Response checker for the nearest-point-within-radius search block.
// Watches the request, response and radius write ports, predicts every response
// and compares it; depends on npwr_pkg for the request and response structs.
module nearest_point_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  wire                             i_in_ready,
    input  npwr_pkg::t_in_req               i_in_req,
    input  wire                             i_out_valid,
    input  wire                             i_out_ready,
    input  npwr_pkg::t_out_rsp              i_out_rsp,
    input  wire                             i_cfg_we,
    input  wire  [npwr_pkg::RADIUS_W-1:0]   i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int MAX_POINTS = npwr_pkg::MAX_POINTS;
    localparam int COORD_BITS = npwr_pkg::COORD_BITS;
    localparam int RADIUS_W   = npwr_pkg::RADIUS_W;
    localparam int INDEX_W    = npwr_pkg::INDEX_W;
    localparam int DIST_W     = npwr_pkg::DIST_W;
    localparam logic [DIST_W-1:0] DIST_CAP = '1;
    localparam int REPORT_LIMIT = 10;

    npwr_pkg::t_point    stored_pts [MAX_POINTS];
    int unsigned         stored_count;
    logic [RADIUS_W-1:0] radius;
    npwr_pkg::t_out_rsp  awaited_rsps [$];
    int                  mismatch_count;

    // A difference of 2^26 or more would overflow the distance width.
    function automatic logic [DIST_W-1:0] axis_sq(logic [COORD_BITS-1:0] a,
                                                  logic [COORD_BITS-1:0] b);
        longint diff;
        diff = longint'($signed(a)) - longint'($signed(b));
        if (diff < 0) begin
            diff = -diff;
        end
        if (diff >= (longint'(1) << (DIST_W / 2))) begin
            return DIST_CAP;
        end
        return DIST_W'(diff * diff);
    endfunction

    function automatic logic [DIST_W-1:0] sum_capped(logic [DIST_W-1:0] a,
                                                     logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_CAP : s[DIST_W-1:0];
    endfunction

    // Only a strictly smaller distance replaces the best, so ties keep the lowest index.
    function automatic npwr_pkg::t_out_rsp nearest_within_radius(npwr_pkg::t_point q);
        npwr_pkg::t_out_rsp rsp;
        logic [DIST_W-1:0]  best;
        logic [DIST_W-1:0]  d;
        int                 i;
        rsp = '0;
        best = DIST_W'(radius) * DIST_W'(radius);
        for (i = 0; i < stored_count; i++) begin
            d = sum_capped(sum_capped(axis_sq(stored_pts[i].x, q.x),
                                      axis_sq(stored_pts[i].y, q.y)),
                           axis_sq(stored_pts[i].z, q.z));
            if (d < best) begin
                best = d;
                rsp.found = 1'b1;
                rsp.match_index = INDEX_W'(i);
                rsp.best_dist_sq = d;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        npwr_pkg::t_out_rsp exp_rsp;
        if (!i_rst_n) begin
            stored_count = 0;
            radius = npwr_pkg::RADIUS_RESET;
            awaited_rsps.delete();
            mismatch_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_rsps.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: response with no request outstanding:", $realtime);
                        $display("%0t:   found=%0d index=%0d dist=%0d status=%0d",
                                 $realtime, i_out_rsp.found, i_out_rsp.match_index,
                                 i_out_rsp.best_dist_sq, i_out_rsp.status);
                    end
                    mismatch_count++;
                end else begin
                    exp_rsp = awaited_rsps.pop_front();
                    if (i_out_rsp.found !== exp_rsp.found
                            || i_out_rsp.match_index !== exp_rsp.match_index
                            || i_out_rsp.best_dist_sq !== exp_rsp.best_dist_sq
                            || i_out_rsp.status !== exp_rsp.status) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("%0t: expected found=%0d index=%0d dist=%0d status=%0d",
                                     $realtime, exp_rsp.found, exp_rsp.match_index,
                                     exp_rsp.best_dist_sq, exp_rsp.status);
                            $display("%0t: got      found=%0d index=%0d dist=%0d status=%0d",
                                     $realtime, i_out_rsp.found, i_out_rsp.match_index,
                                     i_out_rsp.best_dist_sq, i_out_rsp.status);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                radius = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                exp_rsp = '0;
                case (i_in_req.action)
                    npwr_pkg::ACT_CLEAR: begin
                        stored_count = 0;
                    end
                    npwr_pkg::ACT_LOAD: begin
                        if (stored_count >= MAX_POINTS) begin
                            exp_rsp.status = 1'b1;
                        end else begin
                            stored_pts[stored_count] = '{x: i_in_req.coord_x,
                                                         y: i_in_req.coord_y,
                                                         z: i_in_req.coord_z};
                            stored_count++;
                        end
                    end
                    npwr_pkg::ACT_QUERY: begin
                        exp_rsp = nearest_within_radius('{x: i_in_req.coord_x,
                                                          y: i_in_req.coord_y,
                                                          z: i_in_req.coord_z});
                    end
                    default: begin
                        // The reserved action leaves the store alone and answers zero.
                    end
                endcase
                awaited_rsps.insert(awaited_rsps.size(), exp_rsp);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending <= awaited_rsps.size();
    end

endmodule

// ===== bench/tb_nearest_point_within_radius_top.sv =====
// Testbench top for the nearest-point-within-radius search block.
// Drives requests, response stalls and radius writes, and gives the verdict;
// depends on npwr_pkg, the block and nearest_point_checker.
module tb_nearest_point_within_radius_top;

    localparam int MAX_POINTS = npwr_pkg::MAX_POINTS;
    localparam int COORD_BITS = npwr_pkg::COORD_BITS;
    localparam int RADIUS_W   = npwr_pkg::RADIUS_W;
    localparam npwr_pkg::t_action ACT_RESERVED = npwr_pkg::t_action'(2'd3);
    localparam int MAX_GAP = 16;
    localparam int PHASE_ITEMS = 93;
    localparam int RANDOM_PHASES = 6;
    localparam int STORE_SOFT_LIMIT = 48;
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
    localparam int DRAIN_CYCLES = 200000;
    localparam int SETTLE_CYCLES = MAX_POINTS + 16;
    localparam int TIMEOUT_CYCLES = 1000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    npwr_pkg::t_in_req   in_req = '0;
    logic                out_ready = 1'b0;
    logic                cfg_we = 1'b0;
    logic [RADIUS_W-1:0] cfg_data = '0;
    wire                 o_in_ready;
    wire                 o_out_valid;
    npwr_pkg::t_out_rsp  o_out_rsp;
    int                  fail_count;
    int                  pending;

    npwr_pkg::t_point    loaded_pts [MAX_POINTS];
    int                  loaded_count = 0;
    logic [RADIUS_W-1:0] cur_radius = npwr_pkg::RADIUS_RESET;
    bit                  in_quiet = 1'b0;
    bit                  out_quiet = 1'b0;

    nearest_point_within_radius_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    nearest_point_checker answer_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_rsp    (o_out_rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * TIMEOUT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

    // Now and then a side switches between random gaps and back-to-back traffic.
    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 23) == 0) begin
            quiet = !quiet;
        end
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic npwr_pkg::t_point pt(int x, int y, int z);
        return '{x: COORD_BITS'(x), y: COORD_BITS'(y), z: COORD_BITS'(z)};
    endfunction

    function automatic npwr_pkg::t_point any_point();
        return '{x: COORD_BITS'($urandom), y: COORD_BITS'($urandom),
                 z: COORD_BITS'($urandom)};
    endfunction

    function automatic npwr_pkg::t_point near_point(npwr_pkg::t_point p, int span);
        npwr_pkg::t_point q;
        q.x = p.x + COORD_BITS'($urandom_range(0, 2 * span) - span);
        q.y = p.y + COORD_BITS'($urandom_range(0, 2 * span) - span);
        q.z = p.z + COORD_BITS'($urandom_range(0, 2 * span) - span);
        return q;
    endfunction

    function automatic npwr_pkg::t_point pick_loaded();
        return loaded_pts[$urandom_range(0, loaded_count - 1)];
    endfunction

    // Valid stays high across back-to-back requests and is dropped only for a gap.
    task automatic send_req(npwr_pkg::t_action act, npwr_pkg::t_point p);
        int gap;
        gap = draw_gap(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= '{action: act, coord_x: p.x, coord_y: p.y, coord_z: p.z};
        do @(posedge i_clk); while (!o_in_ready);
        if (act == npwr_pkg::ACT_CLEAR) begin
            loaded_count = 0;
        end else if (act == npwr_pkg::ACT_LOAD && loaded_count < MAX_POINTS) begin
            loaded_pts[loaded_count] = p;
            loaded_count++;
        end
    endtask

    task automatic set_radius(logic [RADIUS_W-1:0] r);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= r;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_radius = r;
    endtask

    // Loads and queries mostly land near stored points so that hits and near misses
    // around the radius are common; the store is cleared before scans get long.
    task automatic random_item();
        npwr_pkg::t_point p;
        int               pick;
        int               sub;
        int               span;
        span = (cur_radius == 0) ? 8 : int'(cur_radius);
        pick = $urandom_range(0, 99);
        if (loaded_count >= STORE_SOFT_LIMIT || pick < 4) begin
            send_req(npwr_pkg::ACT_CLEAR, any_point());
        end else if (pick < 8) begin
            send_req(ACT_RESERVED, any_point());
        end else begin
            sub = $urandom_range(0, 5);
            if (loaded_count == 0 || sub == 0) begin
                p = any_point();
            end else if (sub == 1) begin
                p = pick_loaded();
            end else begin
                p = near_point(pick_loaded(), span);
            end
            send_req(pick < 50 ? npwr_pkg::ACT_LOAD : npwr_pkg::ACT_QUERY, p);
        end
    endtask

    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            gap = draw_gap(out_quiet);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [RADIUS_W-1:0] r;
        int                  phase;
        int                  waited;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first at the reset radius of 1.0, then at radius zero and at the largest radius.
        send_req(npwr_pkg::ACT_QUERY, pt(0, 0, 0));
        send_req(ACT_RESERVED, pt(-1, -1, -1));
        send_req(npwr_pkg::ACT_LOAD, pt(0, 0, 0));
        send_req(npwr_pkg::ACT_LOAD, pt(COORD_MAX, COORD_MAX, COORD_MAX));
        send_req(npwr_pkg::ACT_LOAD, pt(COORD_MIN, COORD_MIN, COORD_MIN));
        send_req(npwr_pkg::ACT_LOAD, pt(0, 0, 0));
        send_req(npwr_pkg::ACT_LOAD, pt(1023, 0, 0));
        send_req(npwr_pkg::ACT_LOAD, pt(1024, 0, 0));
        send_req(ACT_RESERVED, pt(0, 0, 0));
        send_req(npwr_pkg::ACT_QUERY, pt(0, 0, 0));
        send_req(npwr_pkg::ACT_QUERY, pt(2047, 0, 0));
        send_req(npwr_pkg::ACT_QUERY, pt(2048, 0, 0));
        send_req(npwr_pkg::ACT_QUERY, pt(COORD_MAX, COORD_MAX, COORD_MAX));
        send_req(npwr_pkg::ACT_QUERY, pt(COORD_MIN, COORD_MIN, COORD_MIN));
        send_req(npwr_pkg::ACT_QUERY, pt(-1, -1, -1));
        set_radius('0);
        send_req(npwr_pkg::ACT_QUERY, pt(0, 0, 0));
        set_radius(RADIUS_MAX);
        send_req(npwr_pkg::ACT_QUERY, pt(4000000, 0, 0));
        send_req(npwr_pkg::ACT_QUERY, pt(COORD_MAX, COORD_MIN, COORD_MAX));
        send_req(npwr_pkg::ACT_CLEAR, pt(0, 0, 0));
        send_req(npwr_pkg::ACT_QUERY, pt(0, 0, 0));

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: r = '0;
                1: r = RADIUS_MAX;
                2: r = npwr_pkg::RADIUS_RESET;
                3: r = RADIUS_W'($urandom_range(1, 4096));
                4: r = RADIUS_W'($urandom_range(4097, RADIUS_MAX));
                default: r = RADIUS_W'($urandom_range(1, 65535));
            endcase
            set_radius(r);
            repeat (PHASE_ITEMS) random_item();
        end

        in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_CYCLES);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
